### hdl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned CHANNEL_BITS      = 8;
  localparam int unsigned HUE_FRACTION_BITS = 8;
  localparam int unsigned HUE_BITS          = 9 + HUE_FRACTION_BITS;
  localparam int unsigned FRAC_BITS         = 8;

  localparam longint unsigned CH_MAX      = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam longint unsigned FRAC_ONE    = 64'd1 << FRAC_BITS;
  localparam longint unsigned FULL_SCALE  = CH_MAX * FRAC_ONE;
  localparam longint unsigned SECTOR_SPAN = 64'd60 << HUE_FRACTION_BITS;

  localparam int unsigned SECTOR_LIMIT =
      int'(((64'd1 << HUE_BITS) - 64'd1) / SECTOR_SPAN);
  localparam int unsigned QUOT_BITS = $clog2(SECTOR_LIMIT + 1);
  localparam int unsigned REM_BITS  = $clog2(SECTOR_SPAN);

  localparam int unsigned     FRAC_SHIFT = 2 * REM_BITS;
  localparam longint unsigned FRAC_RECIP =
      ((64'd1 << FRAC_SHIFT) * FRAC_ONE + SECTOR_SPAN - 64'd1) / SECTOR_SPAN;
  localparam int unsigned     FRAC_RECIP_BITS = $clog2(FRAC_RECIP + 64'd1);

  localparam int unsigned NUM_BITS   = CHANNEL_BITS + FRAC_BITS;
  localparam int unsigned SCALE_BITS = 2 * CHANNEL_BITS;

  localparam int unsigned     DIV_SHIFT = SCALE_BITS + CHANNEL_BITS;
  localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + CH_MAX - 64'd1) / CH_MAX;
  localparam int unsigned     DIV_RECIP_BITS = $clog2(DIV_RECIP + 64'd1);

  localparam int unsigned S_TDATA_BITS = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  typedef logic [CHANNEL_BITS-1:0] channel_t;

  typedef struct packed {
    sector_e              sector;
    logic [FRAC_BITS-1:0] frac;
    channel_t             sat;
    channel_t             val;
  } hsv2rgb_hue_t;

  typedef struct packed {
    sector_e  sector;
    channel_t val;
    channel_t p;
    channel_t q;
    channel_t t;
  } hsv2rgb_level_t;

endpackage

`default_nettype wire

### hdl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// HSV to RGB colour converter. Each input word carries hue (1/256 degree units), saturation
// and value; each output word carries red, green and blue, truncated to 8 bits. The block
// takes one word per clock while the pipeline is not stalled and returns each result in
// order; sector search, fraction reciprocal multiply, blend numerators, value multiply,
// reciprocal divide by full scale and channel routing each hold one register stage.
// Back-pressure on the output stalls the pipeline only once every stage is full. A hue of
// 360 degrees or more falls in the last sector; zero saturation gives grey.
module hsv_to_rgb_converter (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [hsv2rgb_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,  // hue, saturation, brightness
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [hsv2rgb_pkg::M_TDATA_BITS-1:0]  m_axis_tdata   // red, green, blue
);
  import hsv2rgb_pkg::*;

  localparam int unsigned SatLo = HUE_BITS;
  localparam int unsigned ValLo = HUE_BITS + CHANNEL_BITS;

  logic           hue_valid;
  logic           hue_ready;
  hsv2rgb_hue_t   hue_word;
  logic           lvl_valid;
  logic           lvl_ready;
  hsv2rgb_level_t lvl_word;

  channel_t red;
  channel_t green;
  channel_t blue;

  logic     out_valid_q;
  channel_t red_q;
  channel_t green_q;
  channel_t blue_q;

  hsv2rgb_sector u_sector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .hue_i       (s_axis_tdata[HUE_BITS-1:0]),
    .sat_i       (s_axis_tdata[SatLo+CHANNEL_BITS-1:SatLo]),
    .val_i       (s_axis_tdata[ValLo+CHANNEL_BITS-1:ValLo]),
    .out_valid_o (hue_valid),
    .out_ready_i (hue_ready),
    .out_o       (hue_word)
  );

  hsv2rgb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hue_valid),
    .in_ready_o  (hue_ready),
    .in_i        (hue_word),
    .out_valid_o (lvl_valid),
    .out_ready_i (lvl_ready),
    .out_o       (lvl_word)
  );

  always_comb begin
    unique case (lvl_word.sector)
      SEC_RED: begin
        red = lvl_word.val; green = lvl_word.t;   blue = lvl_word.p;
      end
      SEC_YELLOW: begin
        red = lvl_word.q;   green = lvl_word.val; blue = lvl_word.p;
      end
      SEC_GREEN: begin
        red = lvl_word.p;   green = lvl_word.val; blue = lvl_word.t;
      end
      SEC_CYAN: begin
        red = lvl_word.p;   green = lvl_word.q;   blue = lvl_word.val;
      end
      SEC_BLUE: begin
        red = lvl_word.t;   green = lvl_word.p;   blue = lvl_word.val;
      end
      default: begin
        red = lvl_word.val; green = lvl_word.p;   blue = lvl_word.q;
      end
    endcase
  end

  assign lvl_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lvl_ready) begin
      out_valid_q <= lvl_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_ready && lvl_valid) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[CHANNEL_BITS-1:0]                  = red_q;
    m_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]     = green_q;
    m_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]   = blue_q;
  end

  assign m_axis_tvalid = out_valid_q;

  a_level_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_valid |-> (lvl_word.p <= lvl_word.q) && (lvl_word.p <= lvl_word.t) &&
                  (lvl_word.q <= lvl_word.val) && (lvl_word.t <= lvl_word.val))
    else $error("blend levels out of order");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output word present straight after reset");

endmodule

`default_nettype wire

### hdl/hsv2rgb_sector.sv
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_sector (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [hsv2rgb_pkg::HUE_BITS-1:0]     hue_i,
  input  wire  [hsv2rgb_pkg::CHANNEL_BITS-1:0] sat_i,
  input  wire  [hsv2rgb_pkg::CHANNEL_BITS-1:0] val_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output hsv2rgb_pkg::hsv2rgb_hue_t            out_o
);
  import hsv2rgb_pkg::*;

  logic [QUOT_BITS-1:0]                quot;
  logic [HUE_BITS-1:0]                 span_base;
  logic [REM_BITS-1:0]                 rem;
  sector_e                             sector;
  logic [REM_BITS+FRAC_RECIP_BITS-1:0] frac_prod;

  logic                s1_valid_q;
  logic                s1_ready;
  sector_e             s1_sector_q;
  logic [REM_BITS-1:0] s1_rem_q;
  channel_t            s1_sat_q;
  channel_t            s1_val_q;

  logic                s2_valid_q;
  logic                s2_ready;
  hsv2rgb_hue_t        s2_q;

  always_comb begin
    quot = '0;
    for (int k = 1; k <= SECTOR_LIMIT; k++) begin
      if (hue_i >= HUE_BITS'(k * SECTOR_SPAN)) begin
        quot = QUOT_BITS'(k);
      end
    end
    span_base = HUE_BITS'(quot * SECTOR_SPAN);
    rem       = REM_BITS'(hue_i - span_base);
    if (quot > QUOT_BITS'(SEC_MAGENTA)) begin
      sector = SEC_MAGENTA;
    end else begin
      sector = sector_e'(quot[$bits(sector_e)-1:0]);
    end
  end

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  assign frac_prod = s1_rem_q * FRAC_RECIP_BITS'(FRAC_RECIP);

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_sector_q <= sector;
      s1_rem_q    <= rem;
      s1_sat_q    <= sat_i;
      s1_val_q    <= val_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q.sector <= s1_sector_q;
      s2_q.frac   <= FRAC_BITS'(frac_prod >> FRAC_SHIFT);
      s2_q.sat    <= s1_sat_q;
      s2_q.val    <= s1_val_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

endmodule

`default_nettype wire

### hdl/hsv2rgb_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_blend (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire hsv2rgb_pkg::hsv2rgb_hue_t in_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output hsv2rgb_pkg::hsv2rgb_level_t  out_o
);
  import hsv2rgb_pkg::*;

  logic [FRAC_BITS:0]             frac_inv;
  logic [NUM_BITS-1:0]            sat_frac;
  logic [NUM_BITS-1:0]            sat_inv;
  logic [NUM_BITS-1:0]            num_q;
  logic [NUM_BITS-1:0]            num_t;
  channel_t                       num_p;

  logic                s3_valid_q;
  logic                s3_ready;
  sector_e             s3_sector_q;
  channel_t            s3_val_q;
  channel_t            s3_num_p_q;
  logic [NUM_BITS-1:0] s3_num_q_q;
  logic [NUM_BITS-1:0] s3_num_t_q;

  logic [SCALE_BITS-1:0]            prod_p;
  logic [CHANNEL_BITS+NUM_BITS-1:0] prod_q;
  logic [CHANNEL_BITS+NUM_BITS-1:0] prod_t;

  logic                  s4_valid_q;
  logic                  s4_ready;
  sector_e               s4_sector_q;
  channel_t              s4_val_q;
  logic [SCALE_BITS-1:0] s4_x_p_q;
  logic [SCALE_BITS-1:0] s4_x_q_q;
  logic [SCALE_BITS-1:0] s4_x_t_q;

  logic [SCALE_BITS+DIV_RECIP_BITS-1:0] quot_p;
  logic [SCALE_BITS+DIV_RECIP_BITS-1:0] quot_q;
  logic [SCALE_BITS+DIV_RECIP_BITS-1:0] quot_t;

  logic           s5_valid_q;
  logic           s5_ready;
  hsv2rgb_level_t s5_q;

  always_comb begin
    frac_inv = (FRAC_BITS+1)'(FRAC_ONE) - {1'b0, in_i.frac};
    sat_frac = in_i.sat * in_i.frac;
    sat_inv  = in_i.sat * frac_inv;
    num_p    = CHANNEL_BITS'(CH_MAX) - in_i.sat;
    num_q    = NUM_BITS'(FULL_SCALE) - sat_frac;
    num_t    = NUM_BITS'(FULL_SCALE) - sat_inv;
  end

  assign prod_p = s3_val_q * s3_num_p_q;
  assign prod_q = s3_val_q * s3_num_q_q;
  assign prod_t = s3_val_q * s3_num_t_q;

  assign quot_p = s4_x_p_q * DIV_RECIP_BITS'(DIV_RECIP);
  assign quot_q = s4_x_q_q * DIV_RECIP_BITS'(DIV_RECIP);
  assign quot_t = s4_x_t_q * DIV_RECIP_BITS'(DIV_RECIP);

  assign s5_ready   = !s5_valid_q || out_ready_i;
  assign s4_ready   = !s4_valid_q || s5_ready;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign in_ready_o = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= in_valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
      if (s5_ready) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      s3_sector_q <= in_i.sector;
      s3_val_q    <= in_i.val;
      s3_num_p_q  <= num_p;
      s3_num_q_q  <= num_q;
      s3_num_t_q  <= num_t;
    end
    if (s4_ready && s3_valid_q) begin
      s4_sector_q <= s3_sector_q;
      s4_val_q    <= s3_val_q;
      s4_x_p_q    <= prod_p;
      s4_x_q_q    <= prod_q[CHANNEL_BITS+NUM_BITS-1:FRAC_BITS];
      s4_x_t_q    <= prod_t[CHANNEL_BITS+NUM_BITS-1:FRAC_BITS];
    end
    if (s5_ready && s4_valid_q) begin
      s5_q.sector <= s4_sector_q;
      s5_q.val    <= s4_val_q;
      s5_q.p      <= CHANNEL_BITS'(quot_p >> DIV_SHIFT);
      s5_q.q      <= CHANNEL_BITS'(quot_q >> DIV_SHIFT);
      s5_q.t      <= CHANNEL_BITS'(quot_t >> DIV_SHIFT);
    end
  end

  assign out_valid_o = s5_valid_q;
  assign out_o       = s5_q;

endmodule

`default_nettype wire
